### hdl/bapc_pkg.sv
// Package for the buzzer alarm and prompt controller.
// Holds event, mode and register codes and the structs shared by the modules.
// No dependencies.
`default_nettype none

package bapc_pkg;

    localparam int DUR_W    = 16;
    localparam int REG_W    = 16;
    localparam int CNT_W    = 32;
    localparam int MS_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_MODE  = 2'd1;
    localparam logic [1:0] KIND_ALARM = 2'd2;
    localparam logic [1:0] KIND_BEEP  = 2'd3;

    localparam logic [1:0] MODE_AUTO    = 2'd0;
    localparam logic [1:0] MODE_OFF     = 2'd1;
    localparam logic [1:0] MODE_ON      = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_DEFAULT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_MAX     = 2'd2;

    localparam logic [REG_W-1:0] RST_ALARM_INTERVAL = 16'd40;
    localparam logic [REG_W-1:0] RST_PROMPT_DEFAULT = 16'd60;
    localparam logic [REG_W-1:0] RST_PROMPT_MAX     = 16'd1000;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       mode_value;
        logic             alarm_level;
        logic [DUR_W-1:0] dur_req;
    } t_item;

    typedef struct packed {
        logic [REG_W-1:0] alarm_interval;
        logic [REG_W-1:0] prompt_default;
        logic [REG_W-1:0] prompt_max;
    } t_cfg;

    typedef struct packed {
        logic             buzzer_on;
        logic             alarm_set;
        logic [1:0]       mode;
        logic [CNT_W-1:0] change_count;
        logic [CNT_W-1:0] tick_total;
        logic [REG_W-1:0] prompt_ticks;
        logic             bad_mode;
    } t_status;

endpackage

`default_nettype wire

### hdl/bapc_in_if.sv
// Event channel of the buzzer controller: valid, ready and one event.
// Depends on bapc_pkg for the field widths.
`default_nettype none

interface bapc_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [1:0]                mode_value;
    logic                      alarm_level;
    logic [bapc_pkg::DUR_W-1:0] dur_req;

    modport source (output valid, kind, mode_value, alarm_level, dur_req, input ready);
    modport sink   (input valid, kind, mode_value, alarm_level, dur_req, output ready);
endinterface

`default_nettype wire

### hdl/bapc_out_if.sv
// Result channel of the buzzer controller: valid, ready and one status item.
// Depends on bapc_pkg for the field widths.
`default_nettype none

interface bapc_out_if;
    logic                      valid;
    logic                      ready;
    logic                      buzzer_on;
    logic                      alarm_is_active;
    logic                      prompt_is_active;
    logic [1:0]                mode_now;
    logic [bapc_pkg::CNT_W-1:0] change_count;
    logic [bapc_pkg::CNT_W-1:0] tick_total;
    logic [bapc_pkg::MS_W-1:0]  prompt_left_ms;
    logic                      bad_mode;

    modport source (output valid, buzzer_on, alarm_is_active, prompt_is_active, mode_now,
                     change_count, tick_total, prompt_left_ms, bad_mode, input ready);
    modport sink   (input valid, buzzer_on, alarm_is_active, prompt_is_active, mode_now,
                     change_count, tick_total, prompt_left_ms, bad_mode, output ready);
endinterface

`default_nettype wire

### hdl/bapc_beep_len.sv
// Converts a requested beep length in ms into a tick count.
// Default substitution, clamp to the maximum, ceiling division by TICK_MS, at least one tick.
// Depends on bapc_pkg.
`default_nettype none

module bapc_beep_len #(
    parameter int TICK_MS = 10
) (
    input  wire logic [bapc_pkg::DUR_W-1:0] i_dur_req,
    input  wire logic [bapc_pkg::REG_W-1:0] i_default_ms,
    input  wire logic [bapc_pkg::REG_W-1:0] i_max_ms,
    output logic      [bapc_pkg::REG_W-1:0] o_ticks
);

    // Dividend is the clamped length plus TICK_MS-1, one bit wider than the field.
    localparam int NUM_W  = bapc_pkg::DUR_W + 1;
    localparam int SHIFT  = NUM_W + $clog2(TICK_MS);
    localparam int MULT_W = NUM_W + 1;
    localparam int PROD_W = NUM_W + MULT_W;
    localparam longint unsigned MULT_L =
        ((64'd1 << SHIFT) + longint'(TICK_MS) - 64'd1) / longint'(TICK_MS);
    localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_L);
    localparam logic [NUM_W-1:0]  ROUND_UP = NUM_W'(TICK_MS - 1);
    localparam logic [NUM_W-1:0]  TICK_MAX = NUM_W'({bapc_pkg::REG_W{1'b1}});

    logic [bapc_pkg::DUR_W-1:0] dur_sel;
    logic [bapc_pkg::DUR_W-1:0] dur_clamped;
    logic [NUM_W-1:0]           numer;
    logic [PROD_W-1:0]          product;
    logic [NUM_W-1:0]           quot;

    // The reciprocal is rounded up and one bit wider than the dividend, which
    // makes the shifted product the exact floor over the whole dividend range.
    always_comb begin
        dur_sel     = (i_dur_req == '0) ? i_default_ms : i_dur_req;
        dur_clamped = (dur_sel > i_max_ms) ? i_max_ms : dur_sel;
        numer       = {1'b0, dur_clamped} + ROUND_UP;
        product     = PROD_W'(numer) * PROD_W'(MULT);
        quot        = NUM_W'(product >> SHIFT);
        if (quot == '0) begin
            o_ticks = bapc_pkg::REG_W'(1);
        end else if (quot > TICK_MAX) begin
            o_ticks = {bapc_pkg::REG_W{1'b1}};
        end else begin
            o_ticks = quot[bapc_pkg::REG_W-1:0];
        end
    end

endmodule

`default_nettype wire

### hdl/bapc_state.sv
// Controller state and its next-state logic; the state registers are the result.
// Updates on each advance from the input register.
// Depends on bapc_pkg.
`default_nettype none

module bapc_state (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire bapc_pkg::t_item            i_item,
    input  wire logic [bapc_pkg::REG_W-1:0] i_beep_ticks,
    input  wire logic [bapc_pkg::REG_W-1:0] i_alarm_interval,
    output bapc_pkg::t_status               o_status
);

    logic                       r_drive,      n_drive;
    logic                       r_alarm,      n_alarm;
    logic                       r_phase_on,   n_phase_on;
    logic [bapc_pkg::REG_W-1:0] r_phase_left, n_phase_left;
    logic [bapc_pkg::REG_W-1:0] r_prompt,     n_prompt;
    logic [1:0]                 r_mode,       n_mode;
    logic [bapc_pkg::CNT_W-1:0] r_toggles,    n_toggles;
    logic [bapc_pkg::CNT_W-1:0] r_ticks,      n_ticks;
    logic                       r_bad,        n_bad;
    logic [bapc_pkg::REG_W-1:0] phase_cnt;

    always_comb begin
        n_drive      = r_drive;
        n_alarm      = r_alarm;
        n_phase_on   = r_phase_on;
        n_phase_left = r_phase_left;
        n_prompt     = r_prompt;
        n_mode       = r_mode;
        n_ticks      = r_ticks;
        n_bad        = 1'b0;
        phase_cnt    = r_phase_left;

        unique case (i_item.kind)
            bapc_pkg::KIND_TICK: begin
                n_ticks = r_ticks + 1'b1;
                priority if (r_mode == bapc_pkg::MODE_ON) begin
                    n_drive = 1'b1;
                end else if (r_mode == bapc_pkg::MODE_OFF) begin
                    n_drive = 1'b0;
                end else if (r_prompt != '0) begin
                    n_prompt = r_prompt - 1'b1;
                    n_drive  = 1'b1;
                end else if (r_alarm) begin
                    if (phase_cnt != '0) begin
                        phase_cnt = phase_cnt - 1'b1;
                    end
                    if (phase_cnt == '0) begin
                        n_phase_on = ~r_phase_on;
                        phase_cnt  = i_alarm_interval;
                    end
                    n_phase_left = phase_cnt;
                    n_drive      = n_phase_on;
                end else begin
                    n_drive = 1'b0;
                end
            end
            bapc_pkg::KIND_MODE: begin
                if (i_item.mode_value == bapc_pkg::MODE_INVALID) begin
                    n_bad = 1'b1;
                end else begin
                    n_mode = i_item.mode_value;
                    priority if (i_item.mode_value == bapc_pkg::MODE_OFF) begin
                        n_drive = 1'b0;
                    end else if (i_item.mode_value == bapc_pkg::MODE_ON) begin
                        n_drive = 1'b1;
                    end else begin
                        n_drive = (r_prompt != '0) | (r_alarm & r_phase_on);
                    end
                end
            end
            bapc_pkg::KIND_ALARM: begin
                if (i_item.alarm_level) begin
                    // A second activation keeps the phase that is running.
                    if (!r_alarm) begin
                        n_phase_on   = 1'b1;
                        n_phase_left = i_alarm_interval;
                    end
                    n_alarm = 1'b1;
                end else begin
                    n_alarm      = 1'b0;
                    n_phase_on   = 1'b0;
                    n_phase_left = '0;
                end
                if (r_mode == bapc_pkg::MODE_AUTO) begin
                    n_drive = (r_prompt != '0) | (n_alarm & n_phase_on);
                end
            end
            bapc_pkg::KIND_BEEP: begin
                n_prompt = i_beep_ticks;
                if (r_mode == bapc_pkg::MODE_AUTO || r_mode == bapc_pkg::MODE_ON) begin
                    n_drive = 1'b1;
                end
            end
            default: begin
                n_bad = 1'b0;
            end
        endcase

        n_toggles = r_toggles + bapc_pkg::CNT_W'(n_drive != r_drive);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive      <= 1'b0;
            r_alarm      <= 1'b0;
            r_phase_on   <= 1'b0;
            r_phase_left <= '0;
            r_prompt     <= '0;
            r_mode       <= bapc_pkg::MODE_AUTO;
            r_toggles    <= '0;
            r_ticks      <= '0;
            r_bad        <= 1'b0;
        end else if (i_advance) begin
            r_drive      <= n_drive;
            r_alarm      <= n_alarm;
            r_phase_on   <= n_phase_on;
            r_phase_left <= n_phase_left;
            r_prompt     <= n_prompt;
            r_mode       <= n_mode;
            r_toggles    <= n_toggles;
            r_ticks      <= n_ticks;
            r_bad        <= n_bad;
        end
    end

    always_comb begin
        o_status.buzzer_on    = r_drive;
        o_status.alarm_set    = r_alarm;
        o_status.mode         = r_mode;
        o_status.change_count = r_toggles;
        o_status.tick_total   = r_ticks;
        o_status.prompt_ticks = r_prompt;
        o_status.bad_mode     = r_bad;
    end

endmodule

`default_nettype wire

### hdl/buzzer_alarm_prompt_controller_unit.sv
// Buzzer alarm and prompt controller, top level.
// Events enter on i_in (tick, set mode, set alarm, beep); one status
// transaction per event leaves on o_out, in order. The user must write the
// registers on the plain port i_cfg_we / i_cfg_idx / i_cfg_data only while
// no event is in flight; the block does not enforce it. Indexes beyond the
// register list are ignored. An accepted event is held in an input register,
// and when it advances the state update and the beep length conversion run
// in one pass into the state registers, which are the result register. One
// event a cycle is taken sustained while the receiver takes every result. If
// the receiver stalls, the result holds and one more event is still taken
// into the input register before i_in.ready drops.
// Synchronous reset (i_rst_n low) clears both stages, puts the buzzer off in
// auto mode with zeroed counters and loads the register defaults (interval
// 40 ticks, default beep 60 ms, maximum beep 1000 ms). The block is ready to
// accept events on the first cycle after reset.
// Depends on bapc_pkg, bapc_in_if, bapc_out_if, bapc_beep_len and bapc_state.
`default_nettype none

module buzzer_alarm_prompt_controller_unit #(
    parameter int TICK_MS = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    bapc_in_if.sink                             i_in,
    bapc_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [bapc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bapc_pkg::REG_W-1:0]     i_cfg_data
);

    localparam int MS_PROD_W = bapc_pkg::REG_W + $clog2(TICK_MS + 1);

    bapc_pkg::t_cfg    r_cfg;
    bapc_pkg::t_item   r_item;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              advance;
    logic [bapc_pkg::REG_W-1:0] beep_ticks;
    logic [MS_PROD_W-1:0]       left_ms_wide;
    bapc_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_interval <= bapc_pkg::RST_ALARM_INTERVAL;
            r_cfg.prompt_default <= bapc_pkg::RST_PROMPT_DEFAULT;
            r_cfg.prompt_max     <= bapc_pkg::RST_PROMPT_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bapc_pkg::CFG_ALARM_INTERVAL: r_cfg.alarm_interval <= i_cfg_data;
                bapc_pkg::CFG_PROMPT_DEFAULT: r_cfg.prompt_default <= i_cfg_data;
                bapc_pkg::CFG_PROMPT_MAX:     r_cfg.prompt_max     <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // The held event moves on whenever the result slot is free or being taken.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.kind        <= i_in.kind;
            r_item.mode_value  <= i_in.mode_value;
            r_item.alarm_level <= i_in.alarm_level;
            r_item.dur_req     <= i_in.dur_req;
        end
    end

    bapc_beep_len #(
        .TICK_MS (TICK_MS)
    ) u_beep_len (
        .i_dur_req     (r_item.dur_req),
        .i_default_ms  (r_cfg.prompt_default),
        .i_max_ms      (r_cfg.prompt_max),
        .o_ticks       (beep_ticks)
    );

    bapc_state u_state (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_item           (r_item),
        .i_beep_ticks     (beep_ticks),
        .i_alarm_interval (r_cfg.alarm_interval),
        .o_status         (status)
    );

    assign left_ms_wide = MS_PROD_W'(status.prompt_ticks) * MS_PROD_W'(TICK_MS);

    always_comb begin
        o_out.valid            = r_out_valid;
        o_out.buzzer_on        = status.buzzer_on;
        o_out.alarm_is_active  = status.alarm_set;
        o_out.prompt_is_active = (status.prompt_ticks != '0);
        o_out.mode_now         = status.mode;
        o_out.change_count     = status.change_count;
        o_out.tick_total       = status.tick_total;
        o_out.prompt_left_ms   = left_ms_wide[bapc_pkg::MS_W-1:0];
        o_out.bad_mode         = status.bad_mode;
    end

endmodule

`default_nettype wire
